// ===== design/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Largest bordered square package
// Widths, types and reset values shared by the largest bordered square block.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int SIDE_W = 6;
  localparam int RUN_W  = 6;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [RUN_W-1:0]  run_t;

  localparam side_t SIDE_RESET = 6'd32;

endpackage

// ===== design/largest_bordered_square_top.sv =====
// ----------------------------------------------------------------------------
// Largest bordered square
// Loads a square binary grid one cell per item, keeps the marked run lengths
// ending at every cell in two memories, then scans every corner and side for
// the largest square whose four borders are all marked.
// Loading each cell reads the run above and then writes the new run lengths.
// The scan then visits each cell and tries candidate sides from the shorter of
// its two runs downwards, all through one read port on each run memory.
// The result item is registered once the scan ends and any earlier result has
// been taken, and the next grid may start loading while it waits. Reset is
// synchronous: the side register returns to 32 and the cell count and best side
// to zero; memories are not cleared.
// ----------------------------------------------------------------------------
module largest_bordered_square_top #(
  parameter int MAX_SIDE = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  lbs_pkg::side_t grid_side,
  input  logic           cell_valid,
  output logic           cell_stall,
  input  logic           cell_marked,
  output logic           result_valid,
  input  logic           result_stall,
  output lbs_pkg::side_t largest_side
);
  import lbs_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_MIN   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state;
  side_t         side_reg;
  side_t         side_eff;
  logic [CW-1:0] row;
  logic [CW-1:0] col;
  logic          bit_reg;
  run_t          prev_h;
  side_t         cand;
  side_t         best;

  run_t horiz_mem [CELLS];
  run_t vert_mem  [CELLS];
  run_t horiz_rd;
  run_t vert_rd;

  logic [AW-1:0] horiz_raddr;
  logic [AW-1:0] vert_raddr;
  logic [AW-1:0] here_addr;
  logic [AW-1:0] above_addr;
  logic [AW-1:0] probe_row_addr;
  logic [AW-1:0] probe_col_addr;
  logic [SIDE_W:0] probe_row;
  logic [SIDE_W:0] probe_col;

  logic  last_row;
  logic  last_col;
  run_t  h_in;
  run_t  v_in;
  run_t  h_new;
  run_t  v_new;
  logic  cell_take;
  logic  cfg_take;

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_SIDE + int'(c));
  endfunction

  always_comb begin
    priority if (side_reg == '0) begin
      side_eff = side_t'(1);
    end else if (int'(side_reg) > MAX_SIDE) begin
      side_eff = side_t'(MAX_SIDE);
    end else begin
      side_eff = side_reg;
    end
  end

  assign cfg_ready  = (state == S_LOAD);
  assign cfg_take   = cfg_valid && cfg_ready;
  assign cell_stall = (state != S_LOAD) || cfg_valid;
  assign cell_take  = cell_valid && !cell_stall;

  assign last_row = (side_t'(row) == side_eff - side_t'(1));
  assign last_col = (side_t'(col) == side_eff - side_t'(1));

  assign probe_row = {1'b0, side_t'(row)} + (SIDE_W+1)'(1) - {1'b0, cand};
  assign probe_col = {1'b0, side_t'(col)} + (SIDE_W+1)'(1) - {1'b0, cand};

  assign here_addr      = slot(row, col);
  assign above_addr     = slot(row - CW'(1), col);
  assign probe_row_addr = slot(CW'(probe_row), col);
  assign probe_col_addr = slot(row, CW'(probe_col));

  always_comb begin
    unique case (state)
      S_PROBE: begin
        horiz_raddr = probe_row_addr;
        vert_raddr  = probe_col_addr;
      end
      S_LOAD: begin
        horiz_raddr = here_addr;
        vert_raddr  = above_addr;
      end
      default: begin
        horiz_raddr = here_addr;
        vert_raddr  = here_addr;
      end
    endcase
  end

  assign h_in  = (col != '0) ? prev_h : '0;
  assign v_in  = (row != '0) ? vert_rd : '0;
  assign h_new = bit_reg ? h_in + run_t'(1) : '0;
  assign v_new = bit_reg ? v_in + run_t'(1) : '0;

  always_ff @(posedge clk) begin
    horiz_rd <= horiz_mem[horiz_raddr];
    vert_rd  <= vert_mem[vert_raddr];
    if (state == S_WRITE) begin
      horiz_mem[here_addr] <= h_new;
      vert_mem[here_addr]  <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      side_reg     <= SIDE_RESET;
      row          <= '0;
      col          <= '0;
      best         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (cfg_take) begin
            side_reg <= grid_side;
            row      <= '0;
            col      <= '0;
            best     <= '0;
          end else if (cell_take) begin
            bit_reg <= cell_marked;
            state   <= S_WRITE;
          end
        end
        S_WRITE: begin
          prev_h <= h_new;
          if (last_col) begin
            col <= '0;
            if (last_row) begin
              row   <= '0;
              best  <= '0;
              state <= S_CELL;
            end else begin
              row   <= row + CW'(1);
              state <= S_LOAD;
            end
          end else begin
            col   <= col + CW'(1);
            state <= S_LOAD;
          end
        end
        S_CELL: begin
          state <= S_MIN;
        end
        S_MIN: begin
          cand  <= (horiz_rd < vert_rd) ? horiz_rd : vert_rd;
          state <= S_PROBE;
        end
        S_PROBE: begin
          state <= (cand > best) ? S_CHECK : S_NEXT;
        end
        S_CHECK: begin
          if (vert_rd >= cand && horiz_rd >= cand) begin
            best  <= cand;
            state <= S_NEXT;
          end else begin
            cand  <= cand - side_t'(1);
            state <= S_PROBE;
          end
        end
        S_NEXT: begin
          if (last_col) begin
            col <= '0;
            if (last_row) begin
              row   <= '0;
              state <= S_DONE;
            end else begin
              row   <= row + CW'(1);
              state <= S_CELL;
            end
          end else begin
            col   <= col + CW'(1);
            state <= S_CELL;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            largest_side <= best;
            result_valid <= 1'b1;
            best         <= '0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) best <= side_eff)
    else $error("Best side exceeds the grid side.");

  assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> (cand > best && cand != '0))
    else $error("Candidate side checked without beating the best side.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("Result presented outside the end of a scan.");

  assert property (@(posedge clk) disable iff (rst) !(cell_take && cfg_take))
    else $error("Cell item and configuration write taken together.");

endmodule
